// ===== rtl/pctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types and constants of the prefix code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int MAX_CODE_LEN  = 16;

    localparam int ENTRY_INDEX_W = 5;
    localparam int SYMBOL_W      = 8;
    localparam int CODE_W        = 16;
    localparam int LENGTH_W      = 5;
    localparam int BYTE_W        = 8;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int ACC_W     = MAX_CODE_LEN;
    localparam int ACC_LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W     = (ACC_W > CODE_W) ? ACC_W : CODE_W;
    localparam int CMPL_W    = (ACC_LEN_W > LENGTH_W) ? ACC_LEN_W : LENGTH_W;
    localparam int BIT_CNT_W = $clog2(BYTE_W);

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_W - 1);

    typedef enum logic [1:0] {
        ST_SYMBOL = 2'd0,
        ST_END    = 2'd1,
        ST_BAD    = 2'd2
    } result_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic tbl_wr;
        logic byte_load;
        logic bit_step;
        logic out_push;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic finished;
        logic step_result;
        logic step_end;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/pctd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_datapath
// Code table, code accumulator, bit shifter, pending result and output word.
// ----------------------------------------------------------------------------
module pctd_datapath
    import pctd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [ENTRY_INDEX_W-1:0] s_entry_index,
    input  logic [SYMBOL_W-1:0]      s_entry_symbol,
    input  logic [CODE_W-1:0]        s_entry_code,
    input  logic [LENGTH_W-1:0]      s_entry_length,
    input  logic [BYTE_W-1:0]        s_data_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SYMBOL_W-1:0]      m_symbol,
    output logic [1:0]               m_status,
    output logic                     m_last
);

    logic [SYMBOL_W-1:0]  sym_reg [TABLE_ENTRIES];
    logic [CODE_W-1:0]    code_reg [TABLE_ENTRIES];
    logic [LENGTH_W-1:0]  len_reg [TABLE_ENTRIES];

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_LEN_W-1:0] acc_len_reg;
    logic                 finished_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic                 pend_valid_reg;
    logic [SYMBOL_W-1:0]  pend_sym_reg;
    result_status_t       pend_status_reg;

    logic                 m_valid_reg;
    logic [SYMBOL_W-1:0]  m_symbol_reg;
    result_status_t       m_status_reg;
    logic                 m_last_reg;

    logic [ACC_W-1:0]         acc_next;
    logic [ACC_LEN_W-1:0]     acc_len_next;
    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] first;
    logic [SYMBOL_W-1:0]      hit_sym;
    logic                     hit_any;
    logic                     hit_end;
    logic                     bad_code;
    logic                     step_result;
    logic [SYMBOL_W-1:0]      new_sym;
    result_status_t           new_status;
    logic                     tbl_in_range;
    logic [IDX_W-1:0]         wr_idx;

    assign tbl_in_range = int'(s_entry_index) < TABLE_ENTRIES;
    assign wr_idx       = IDX_W'(s_entry_index);

    always_comb begin
        acc_next     = (acc_reg << 1) | ACC_W'(byte_reg[BYTE_W-1]);
        acc_len_next = acc_len_reg + ACC_LEN_W'(1);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            match[k] = (len_reg[k] != '0)
                && (CMPL_W'(len_reg[k]) == CMPL_W'(acc_len_next))
                && (CMP_W'(code_reg[k]) == CMP_W'(acc_next));
        end
        first   = match & (~match + TABLE_ENTRIES'(1));
        hit_sym = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            hit_sym = hit_sym | (first[k] ? sym_reg[k] : '0);
        end
        hit_any     = |match;
        hit_end     = first[TABLE_ENTRIES-1];
        bad_code    = !hit_any && (int'(acc_len_next) >= MAX_CODE_LEN);
        step_result = hit_any || bad_code;
        if (hit_end) begin
            new_status = ST_END;
            new_sym    = '0;
        end else if (hit_any) begin
            new_status = ST_SYMBOL;
            new_sym    = hit_sym;
        end else begin
            new_status = ST_BAD;
            new_sym    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                len_reg[k] <= '0;
            end
        end else if (cmd.tbl_wr && tbl_in_range) begin
            len_reg[wr_idx] <= s_entry_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && tbl_in_range) begin
            sym_reg[wr_idx]  <= s_entry_symbol;
            code_reg[wr_idx] <= s_entry_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            acc_len_reg  <= '0;
            finished_reg <= 1'b0;
        end else if (cmd.bit_step) begin
            if (step_result) begin
                acc_reg     <= '0;
                acc_len_reg <= '0;
            end else begin
                acc_reg     <= acc_next;
                acc_len_reg <= acc_len_next;
            end
            if (hit_end) begin
                finished_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_load) begin
            byte_reg    <= s_data_byte;
            bit_cnt_reg <= '0;
        end else if (cmd.bit_step) begin
            byte_reg    <= byte_reg << 1;
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.bit_step && step_result) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.out_push) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bit_step && step_result) begin
            pend_sym_reg    <= new_sym;
            pend_status_reg <= new_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_push) begin
            m_symbol_reg <= pend_sym_reg;
            m_status_reg <= pend_status_reg;
            m_last_reg   <= cmd.out_last;
        end
    end

    assign status.finished    = finished_reg;
    assign status.step_result = step_result;
    assign status.step_end    = hit_end;
    assign status.last_bit    = (bit_cnt_reg == LAST_BIT);
    assign status.pend_valid  = pend_valid_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    // A word is only loaded into the output register when that register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_push |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

    // The accumulator is always cleared before it reaches the maximum code length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(acc_len_reg) < MAX_CODE_LEN)
        else $error("accumulated length reached the maximum code length");

    // No bit is decoded once the end marker has been found.
    assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> !cmd.bit_step)
        else $error("bit decoded after the end marker");

    // A decoded result never overwrites one that is still pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.bit_step && step_result && pend_valid_reg) |-> cmd.out_push)
        else $error("pending result lost");

endmodule

// ===== rtl/pctd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_ctrl
// Controller that sequences table writes, bit decoding and result delivery.
// ----------------------------------------------------------------------------
module pctd_ctrl
    import pctd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_mode) begin
                        cmd.tbl_wr = 1'b1;
                    end else if (!status.finished) begin
                        cmd.byte_load = 1'b1;
                        state_next    = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (status.out_free) begin
                    cmd.bit_step = 1'b1;
                    if (status.step_result && status.pend_valid) begin
                        cmd.out_push = 1'b1;
                    end
                    if (status.step_end || status.last_bit) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.out_push = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/prefix_code_table_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_table_decoder_unit
// Table-driven prefix code decoder with a controller and a datapath.
//
//   Channel  Direction  Word
//   s_       in         table entry write or one compressed byte
//   m_       out        decoded symbol, end marker or bad-code result
//
// A table write is taken in the idle state, and so is a byte after the end
// marker, which is then dropped. A compressed byte is taken, compared with the
// table once per bit, then the final result of the byte is delivered.
// The end marker cuts the bit phase short at the bit that completes it.
// Reset is synchronous and clears the table lengths, accumulator and flags.
// A stalled output word halts bit decoding until it has been taken.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder_unit
    import pctd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [ENTRY_INDEX_W-1:0] s_entry_index,
    input  logic [SYMBOL_W-1:0]      s_entry_symbol,
    input  logic [CODE_W-1:0]        s_entry_code,
    input  logic [LENGTH_W-1:0]      s_entry_length,
    input  logic [BYTE_W-1:0]        s_data_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SYMBOL_W-1:0]      m_symbol,
    output logic [1:0]               m_status,
    output logic                     m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pctd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .status  (status),
        .cmd     (cmd)
    );

    pctd_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_entry_index  (s_entry_index),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_code   (s_entry_code),
        .s_entry_length (s_entry_length),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_status       (m_status),
        .m_last         (m_last)
    );

endmodule
